[hw/rtl/wkmd_pkg.sv]
// Package for the window kNN mean distance unit: payload structs and codes.
// No dependencies.
`timescale 1ns / 1ps
package wkmd_pkg;

    localparam int DIST_W = 48;
    localparam int ROOT_W = 24;
    localparam int DIFF_W = 24;
    localparam int MEAN_W = 25;
    localparam int K_W    = 7;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [MEAN_W-1:0] MEAN_SAT = {MEAN_W{1'b1}};

    localparam logic       OP_REF   = 1'b0;
    localparam logic       OP_POINT = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_REF = 2'd1;
    localparam logic [1:0] ST_FEW    = 2'd2;
    localparam logic [1:0] ST_SMALLK = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic               point_valid;
        logic               is_last;
    } in_item_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_distance;
        logic [1:0]        status;
    } out_item_t;

    // Control from the sequencer to the row of cells.
    typedef struct packed {
        logic clear;   // load every cell with maximum distance
        logic insert;  // insert new distance
        logic shift;   // drain: every cell takes its right neighbour
    } cell_ctrl_t;

endpackage

[hw/rtl/wkmd_cell.sv]
// One cell of the sorted distance row: holds one entry, compares and hands on.
// Depends on wkmd_pkg.
`timescale 1ns / 1ps
module wkmd_cell
    import wkmd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [DIST_W-1:0] new_dist,
    input  logic [DIST_W-1:0] left_dist,   // entry of lower-index neighbour
    input  logic              left_gt,     // neighbour entry > new_dist
    input  logic [DIST_W-1:0] right_dist,  // entry of higher-index neighbour
    output logic [DIST_W-1:0] entry,
    output logic              gt
);

    logic [DIST_W-1:0] dist_reg, dist_next;

    assign gt = dist_reg > new_dist;

    always_comb
    begin
        dist_next = dist_reg;
        if (ctrl.clear)
        begin
            dist_next = DIST_MAX;
        end
        else if (ctrl.shift)
        begin
            dist_next = right_dist;
        end
        else if (ctrl.insert && gt)
        begin
            dist_next = left_gt ? left_dist : new_dist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= DIST_MAX;
        end
        else
        begin
            dist_reg <= dist_next;
        end
    end

    assign entry = dist_reg;

endmodule

[hw/rtl/wkmd_sqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
// Depends on wkmd_pkg.
`timescale 1ns / 1ps
module wkmd_sqrt
    import wkmd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIST_W-1:0] value,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [DIST_W-1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [DIST_W-1:0] val_reg, val_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIST_W+1:0] trial;
    logic [DIST_W+1:0] rem_sh;

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, val_reg[DIST_W-1 -: 2]};
        trial     = {{(DIST_W-ROOT_W){1'b0}}, root_reg, 2'b01};
        if (start)
        begin
            rem_next  = '0;
            root_next = '0;
            val_next  = value;
            cnt_next  = 5'(ROOT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[DIST_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = DIST_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = DIST_W'(rem_sh);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        val_reg  <= val_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[hw/rtl/wkmd_div.sv]
// Restoring divider, one quotient bit per cycle, quotient saturated to 25 bits.
// Depends on wkmd_pkg.
`timescale 1ns / 1ps
module wkmd_div
    import wkmd_pkg::*;
#(
    parameter int SUM_W = 30
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [K_W+1:0]    divisor,
    output logic              done,
    output logic [MEAN_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [K_W+2:0]    rem_reg, rem_next;
    logic [K_W+1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [K_W+2:0]    rem_sh;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[K_W+1:0], quo_reg[SUM_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(SUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = (quo_reg > SUM_W'(MEAN_SAT)) ? MEAN_SAT : MEAN_W'(quo_reg);

endmodule

[hw/rtl/window_knn_mean_distance_unit.sv]
// Top level of the window kNN mean distance unit: distance pipeline, sorted
// cell row, serial root and divider, result sequencer. Uses wkmd_pkg, wkmd_cell,
// wkmd_sqrt and wkmd_div.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------
//  input   | start / busy       | in_item  (in_item_t)
//  result  | result_valid       | result   (out_item_t)
//  config  | cfg_we             | cfg_data (neighbor_count)
//
// A window point passes through saturated differences, squares and sum, then
// insertion into the cell row (each cell compares in parallel and shifts).
// A reference item is stored on accept, then clear_reg clears the row.
// The last item, if the anchor is valid, k is at least 2 and enough points
// were seen, drains k cells through the serial root and the divider (31-bit
// sum at MAX_K = 64); the result is then output and the row cleared.
// Reset clears control state and sets the row to maximum distance at once.
// The receiver cannot stall: the result strobe lasts one cycle.
`timescale 1ns / 1ps
module window_knn_mean_distance_unit
    import wkmd_pkg::*;
#(
    parameter int MAX_K = 64
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  in_item_t       in_item,
    output logic           result_valid,
    output out_item_t      result,
    input  logic           cfg_we,
    input  logic [K_W-1:0] cfg_data
);

    localparam int SUM_W = ROOT_W + $clog2(MAX_K + 1);
    localparam int IDX_W = $clog2(MAX_K + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIFF  = 3'd1;
    localparam logic [2:0] S_SQ    = 3'd2;
    localparam logic [2:0] S_INS   = 3'd3;
    localparam logic [2:0] S_ROOT  = 3'd4;
    localparam logic [2:0] S_RWAIT = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;

    logic [K_W-1:0]     k_reg;
    logic signed [31:0] ref_x_reg, ref_y_reg, ref_z_reg;
    logic               ref_ok_reg;
    logic [K_W-1:0]     seen_reg;
    in_item_t           item_reg;

    logic [DIFF_W-1:0]  dx_reg, dy_reg, dz_reg;
    logic [DIST_W-1:0]  sx_reg, sy_reg, sz_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [IDX_W-1:0]   left_reg;
    logic [1:0]         status_reg;
    logic [MEAN_W-1:0]  mean_reg;

    cell_ctrl_t         ctrl;
    logic [DIST_W-1:0]  cdist [MAX_K];
    logic               cgt   [MAX_K];

    logic               sq_start, sq_done;
    logic [ROOT_W-1:0]  sq_root;
    logic               dv_start, dv_done;
    logic [MEAN_W-1:0]  dv_quo;
    logic [IDX_W-1:0]   k_eff;
    logic               accept;

    // Saturate an exact 33-bit difference to 24 bits, return magnitude.
    function automatic logic [DIFF_W-1:0] sat_mag(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [32:0] d;
        logic [32:0]        m;
        begin
            d = 33'(a) - 33'(b);
            if (d > 33'sd8388607)
                m = 33'd8388607;
            else if (d < -33'sd8388608)
                m = 33'd8388608;
            else
                m = d[32] ? 33'(-d) : 33'(d);
            sat_mag = DIFF_W'(m);
        end
    endfunction

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE) || ctrl.clear;
    assign k_eff  = (int'(k_reg) > MAX_K) ? IDX_W'(MAX_K) : IDX_W'(k_reg);

    // Row of cells: cell 0 holds the smallest distance.
    genvar g;
    generate
        for (g = 0; g < MAX_K; g++)
        begin : g_cell
            wkmd_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_dist   (dist_reg),
                .left_dist  ((g == 0) ? DIST_MAX : cdist[(g == 0) ? 0 : g - 1]),
                .left_gt    ((g == 0) ? 1'b0 : cgt[(g == 0) ? 0 : g - 1]),
                .right_dist ((g == MAX_K - 1) ? DIST_MAX
                                              : cdist[(g == MAX_K - 1) ? g : g + 1]),
                .entry      (cdist[g]),
                .gt         (cgt[g])
            );
        end
    endgenerate

    wkmd_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (cdist[0]),
        .done  (sq_done),
        .root  (sq_root)
    );

    wkmd_div #(.SUM_W(SUM_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (sum_reg),
        .divisor  ((K_W + 2)'(k_eff - 1'b1)),
        .done     (dv_done),
        .quotient (dv_quo)
    );

    logic clear_reg, clear_next;

    // divider starts the cycle after the final root lands in sum_reg
    logic div_go_reg;

    always_comb
    begin
        state_next  = state_reg;
        clear_next  = 1'b0;
        sq_start    = 1'b0;
        dv_start    = 1'b0;
        ctrl.clear  = clear_reg;
        ctrl.insert = 1'b0;
        ctrl.shift  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.opcode == OP_REF)
                        clear_next = 1'b1;
                    else
                        state_next = S_DIFF;
                end
            end
            S_DIFF:  state_next = S_SQ;
            S_SQ:    state_next = S_INS;
            S_INS:
            begin
                ctrl.insert = item_reg.point_valid;
                if (!item_reg.is_last)
                    state_next = S_IDLE;
                else if (!ref_ok_reg || k_eff < IDX_W'(2)
                         || {1'b0, seen_reg} + 8'(item_reg.point_valid) < 8'(k_eff))
                    state_next = S_OUT;
                else
                    state_next = S_ROOT;
            end
            S_ROOT:
            begin
                sq_start   = 1'b1;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (sq_done)
                begin
                    ctrl.shift = 1'b1;
                    if (left_reg == IDX_W'(1))
                        state_next = S_DIV;
                    else
                        state_next = S_ROOT;
                end
            end
            S_DIV:
            begin
                dv_start = div_go_reg;
                if (dv_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                clear_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            clear_reg  <= 1'b0;
            k_reg      <= K_W'(10);
            ref_ok_reg <= 1'b0;
            ref_x_reg  <= '0;
            ref_y_reg  <= '0;
            ref_z_reg  <= '0;
            seen_reg   <= '0;
            left_reg   <= '0;
            div_go_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clear_reg    <= clear_next;
            div_go_reg   <= (state_reg == S_RWAIT) && sq_done && (left_reg == IDX_W'(1));
            result_valid <= (state_reg == S_OUT);
            if (cfg_we)
                k_reg <= cfg_data;
            if (accept && in_item.opcode == OP_REF)
            begin
                ref_x_reg  <= in_item.coord_x;
                ref_y_reg  <= in_item.coord_y;
                ref_z_reg  <= in_item.coord_z;
                ref_ok_reg <= in_item.point_valid;
            end
            if (clear_reg)
                seen_reg <= '0;
            else if (state_reg == S_INS && item_reg.point_valid && seen_reg != '1)
                seen_reg <= seen_reg + 1'b1;
            if (state_reg == S_INS)
                left_reg <= k_eff;
            else if (state_reg == S_RWAIT && sq_done)
                left_reg <= left_reg - 1'b1;
        end
    end

    // differences taken in the accept cycle, squares next, then the sum
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
        dx_reg   <= sat_mag(in_item.coord_x, ref_x_reg);
        dy_reg   <= sat_mag(in_item.coord_y, ref_y_reg);
        dz_reg   <= sat_mag(in_item.coord_z, ref_z_reg);
        sx_reg   <= DIST_W'(dx_reg) * DIST_W'(dx_reg);
        sy_reg   <= DIST_W'(dy_reg) * DIST_W'(dy_reg);
        sz_reg   <= DIST_W'(dz_reg) * DIST_W'(dz_reg);
        if (state_reg == S_SQ)
            dist_reg <= sx_reg + sy_reg + sz_reg;
        if (state_reg == S_INS)
            sum_reg <= '0;
        else if (state_reg == S_RWAIT && sq_done)
            sum_reg <= sum_reg + SUM_W'(sq_root);
        if (state_reg == S_INS)
        begin
            if (!ref_ok_reg)
                status_reg <= ST_NO_REF;
            else if (k_eff < IDX_W'(2))
                status_reg <= ST_SMALLK;
            else
                status_reg <= ST_FEW;
            mean_reg <= '0;
        end
        else if (state_reg == S_DIV && dv_done)
        begin
            status_reg <= ST_OK;
            mean_reg   <= dv_quo;
        end
        result.mean_distance <= mean_reg;
        result.status        <= status_reg;
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> busy)
        else $error("accept possible while working");
    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_OK) |-> (result.mean_distance == '0))
        else $error("error result with nonzero mean");
    a_row_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cdist[0] <= cdist[1]))
        else $error("cell row out of order");
`endif

endmodule

[tb/tb.sv]
// Testbench for window_knn_mean_distance_unit: directed and random windows,
// checked against a behavioural scorer.
// Depends on wkmd_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module tb;
    import wkmd_pkg::*;

    localparam int MAX_K      = 64;
    localparam int STALL_CAP  = 20000;  // cycles with no transaction
    localparam int SETTLE     = 40;     // covers a point that makes no result

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    in_item_t       in_item = '0;
    logic           result_valid;
    out_item_t      result;
    logic           cfg_we = 1'b0;
    logic [K_W-1:0] cfg_data = '0;

    window_knn_mean_distance_unit #(.MAX_K(MAX_K)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_item      (in_item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Scorer state: our own copy of what the unit should hold
    // ---------------------------------------------------------------
    logic signed [31:0] anchor_x, anchor_y, anchor_z;
    logic               anchor_ok;
    logic [DIST_W-1:0]  nearest [MAX_K];
    int                 valid_pts;
    int                 k_reg;

    in_item_t  stim_q[$];     // transactions waiting for the driver
    out_item_t mean_due[$];   // scores still to come out
    int        n_fail;
    int        n_items;
    int        n_scores;
    int        n_status [4];
    int        quiet_cycles;
    bit        no_idle;

    function automatic logic [DIST_W-1:0] sq_axis(logic signed [31:0] p,
                                                  logic signed [31:0] r);
        longint d;
        d = longint'(p) - longint'(r);
        if (d > 64'sd8388607)
            d = 64'sd8388607;
        if (d < -64'sd8388608)
            d = -64'sd8388608;
        if (d < 0)
            d = -d;
        return DIST_W'(d * d);
    endfunction

    // floor square root, one result bit at a time from the top
    function automatic logic [ROOT_W-1:0] floor_root(logic [DIST_W-1:0] v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return ROOT_W'(r);
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < MAX_K; i++)
            nearest[i] = DIST_MAX;
        valid_pts = 0;
    endfunction

    // advance the scorer by one accepted transaction
    function automatic void score_item(in_item_t it);
        logic [DIST_W-1:0] d;
        int                i;
        int                k;
        longint unsigned   total;
        longint unsigned   mean;
        out_item_t         exp_res;
        if (it.opcode == OP_REF)
        begin
            anchor_x  = it.coord_x;
            anchor_y  = it.coord_y;
            anchor_z  = it.coord_z;
            anchor_ok = it.point_valid;
            clear_window();
            return;
        end
        if (it.point_valid)
        begin
            d = sq_axis(it.coord_x, anchor_x) + sq_axis(it.coord_y, anchor_y)
              + sq_axis(it.coord_z, anchor_z);
            if (d < nearest[MAX_K-1])
            begin
                i = MAX_K - 1;
                while (i > 0 && nearest[i-1] > d)
                begin
                    nearest[i] = nearest[i-1];
                    i--;
                end
                nearest[i] = d;
            end
            if (valid_pts < 127)
                valid_pts++;
        end
        if (!it.is_last)
            return;
        k = (k_reg > MAX_K) ? MAX_K : k_reg;
        exp_res = '0;
        if (!anchor_ok)
            exp_res.status = ST_NO_REF;
        else if (k < 2)
            exp_res.status = ST_SMALLK;
        else if (valid_pts < k)
            exp_res.status = ST_FEW;
        else
        begin
            total = 0;
            for (int j = 0; j < k; j++)
                total += floor_root(nearest[j]);
            mean = total / longint'(k - 1);
            exp_res.mean_distance = (mean > MEAN_SAT) ? MEAN_SAT : MEAN_W'(mean);
            exp_res.status = ST_OK;
        end
        mean_due = {mean_due, exp_res};
        clear_window();
    endfunction

    // ---------------------------------------------------------------
    // Driver: start held until taken, random idle gaps between items
    // ---------------------------------------------------------------
    logic taken;
    always @(posedge clk)
    begin
        taken = start && !busy;
        if (taken)
        begin
            score_item(in_item);
            n_items++;
        end
        if (taken || !start)
        begin
            if (stim_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 16))
            begin
                in_item <= stim_q.pop_front();
                start   <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: each strobed result against the oldest expectation
    // ---------------------------------------------------------------
    out_item_t want;
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (mean_due.size() == 0)
            begin
                $error("unexpected result: mean_distance %0d status %0d",
                       result.mean_distance, result.status);
                n_fail++;
            end
            else
            begin
                want = mean_due.pop_front();
                n_scores++;
                n_status[want.status]++;
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    n_fail++;
                end
                if (result.mean_distance !== want.mean_distance)
                begin
                    $error("mean_distance: expected %0d, got %0d",
                           want.mean_distance, result.mean_distance);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: ends the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_CAP)
        begin
            $display("timeout: nothing moved for %0d cycles", STALL_CAP);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic put(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                       logic v, logic last);
        in_item_t it;
        it.opcode      = op;
        it.coord_x     = x;
        it.coord_y     = y;
        it.coord_z     = z;
        it.point_valid = v;
        it.is_last     = last;
        stim_q = {stim_q, it};
    endtask

    // drain everything, then give a trailing point time to settle
    task automatic wait_idle();
        while (stim_q.size() != 0 || start || busy || mean_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_k(int k);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= K_W'(k);
        @(posedge clk);
        cfg_we   <= 1'b0;
        k_reg = k;
    endtask

    function automatic logic [31:0] offset_from(logic [31:0] base);
        case ($urandom_range(0, 9))
            0: return $urandom();                                 // anywhere
            1, 2: return base + $urandom_range(0, 1 << 25) - (1 << 24);
            default: return base + $urandom_range(0, 8191) - 4096;
        endcase
    endfunction

    // one window of random content, mostly well formed
    task automatic rand_window(int npts);
        logic [31:0] bx, by, bz;
        bit          far;
        if ($urandom_range(0, 99) < 90)
        begin
            far = ($urandom_range(0, 3) == 0);
            bx = far ? $urandom() : $urandom_range(0, 1 << 21) - (1 << 20);
            by = far ? $urandom() : $urandom_range(0, 1 << 21) - (1 << 20);
            bz = far ? $urandom() : $urandom_range(0, 1 << 21) - (1 << 20);
            put(OP_REF, bx, by, bz, $urandom_range(0, 99) < 88, 1'($urandom_range(0, 1)));
        end
        else
        begin
            // keep the current anchor: a fresh window around it
            bx = anchor_x;
            by = anchor_y;
            bz = anchor_z;
        end
        for (int i = 0; i < npts; i++)
        begin
            if ($urandom_range(0, 99) < 3)
                put(OP_REF, $urandom(), $urandom(), $urandom(), 1'b1, 1'b0);
            put(OP_POINT, offset_from(bx), offset_from(by), offset_from(bz),
                $urandom_range(0, 99) < 88, i == npts - 1);
        end
    endtask

    int k_plan [9] = '{2, 1, 0, 64, 127, 5, 3, 10, 33};
    int phase_items;
    int k_eff;

    initial
    begin
        n_fail = 0;
        n_items = 0;
        n_scores = 0;
        n_status = '{0, 0, 0, 0};
        quiet_cycles = 0;
        no_idle = 1'b0;
        anchor_x = 0;
        anchor_y = 0;
        anchor_z = 0;
        anchor_ok = 1'b0;
        k_reg = 10;
        clear_window();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, k at its reset value of ten
        put(OP_POINT, 32'd5, 32'd5, 32'd5, 1'b1, 1'b1);               // no anchor yet
        put(OP_REF, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1);                  // last flag ignored
        put(OP_POINT, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0);                // anchor itself
        put(OP_POINT, 32'h7fffffff, 32'h80000000, 32'd0, 1'b1, 1'b0);  // saturates
        put(OP_POINT, 32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1, 1'b0);
        put(OP_POINT, 32'h007fffff, 32'hff800000, 32'h00800000, 1'b1, 1'b0);
        put(OP_POINT, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, 1'b0); // ignored
        put(OP_POINT, 32'd256, 32'd0, 32'd0, 1'b1, 1'b0);
        put(OP_POINT, 32'd0, 32'd256, 32'd0, 1'b1, 1'b0);
        put(OP_POINT, 32'd0, 32'd0, 32'h80000000, 1'b1, 1'b0);
        put(OP_POINT, 32'd1, 32'd1, 32'd1, 1'b1, 1'b0);
        put(OP_POINT, 32'd3, 32'd4, 32'd0, 1'b1, 1'b0);
        put(OP_POINT, 32'h55555555, 32'haaaaaaaa, 32'h12345678, 1'b1, 1'b1);
        put(OP_POINT, 32'd10, 32'd10, 32'd10, 1'b1, 1'b0);             // same anchor
        put(OP_POINT, 32'd20, 32'd20, 32'd20, 1'b1, 1'b1);             // too few
        put(OP_REF, 32'hdeadbeef, 32'h0, 32'h1, 1'b0, 1'b0);           // invalid anchor
        put(OP_POINT, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0);
        put(OP_POINT, 32'd9, 32'd9, 32'd9, 1'b0, 1'b1);
        wait_idle();

        // random phases, each at its own k; register written only when idle
        foreach (k_plan[p])
        begin
            set_k(k_plan[p]);
            no_idle = (p == 3);   // one stretch with the driver never idling
            k_eff = (k_plan[p] > MAX_K) ? MAX_K : k_plan[p];
            phase_items = 0;
            for (int w = 0; phase_items < 30; w++)
            begin
                int npts;
                if (p == 5 && w == 0)
                    npts = 145;   // pushes the valid count past its ceiling
                else if (k_eff < 2)
                    npts = $urandom_range(1, 8);
                else
                    npts = $urandom_range(k_eff - 2, k_eff + 6);
                phase_items += npts + 1;
                rand_window(npts);
            end
            wait_idle();
        end

        $display("%0d transactions in, %0d scores out", n_items, n_scores);
        $display("ok %0d, no anchor %0d, few %0d, small k %0d; k over 0..127",
                 n_status[0], n_status[1], n_status[2], n_status[3]);
        if (n_fail == 0 && mean_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
